// ===== design/pid_three_mode_controller_assert.svh =====
// Assertion macros for the file that checks this block.
// Every check is clocked on i_clk and is off while i_rst_n is low.
`ifndef PID_THREE_MODE_CONTROLLER_ASSERT_SVH
`define PID_THREE_MODE_CONTROLLER_ASSERT_SVH

// The consequence holds in the same cycle as the antecedent.
`define PTMC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptmc same-cycle check failed");

// The consequence holds in the cycle after the antecedent.
`define PTMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptmc next-cycle check failed");

`endif

// ===== design/ptmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptmc_pkg
// Shared codes and types of the three-mode PID controller: item kinds,
// register indexes, modes, and the command and status between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ptmc_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 32;
    localparam int PERIOD_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd6;

    // Controller modes.
    localparam logic [1:0] MODE_DERIV_ERR  = 2'd0;
    localparam logic [1:0] MODE_DERIV_MEAS = 2'd1;
    localparam logic [1:0] MODE_ALL_MEAS   = 2'd2;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    // Saturation bound of products and sums, 2^62.
    localparam logic [63:0] SAT_MAG = 64'h4000_0000_0000_0000;

    // Datapath operations.
    typedef enum logic [3:0] {
        DP_NONE      = 4'd0,
        DP_TICK      = 4'd1,
        DP_CLEAR     = 4'd2,
        DP_CAPTURE   = 4'd3,
        DP_MUL_START = 4'd4,
        DP_MUL_TAKE  = 4'd5,
        DP_DIV_START = 4'd6,
        DP_FINISH    = 4'd7,
        DP_EMIT      = 4'd8
    } t_dp_op;

    // Product being formed by the shared multiplier.
    typedef enum logic [1:0] {
        MS_INTEG = 2'd0,
        MS_PROP  = 2'd1,
        MS_IGAIN = 2'd2,
        MS_DERIV = 2'd3
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic due;
        logic mul_done;
        logic div_done;
    } t_dp_stat;

endpackage

// ===== design/ptmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptmc_ctrl
// Sequencer of the PID controller: accepts items, steps the datapath
// through its four products and the divide, and owns the result valid.
// ----------------------------------------------------------------------------
module ptmc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    output logic               o_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_out_fresh,
    input  ptmc_pkg::t_dp_stat i_stat,
    output ptmc_pkg::t_dp_cmd  o_cmd
);
    import ptmc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MSTART = 7'b0000010,
        S_MRUN   = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DRUN   = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state   r_state, n_state;
    t_mul_sel r_sel, n_sel;
    logic     r_fresh, n_fresh;
    logic     r_out_valid, n_out_valid;
    logic     r_out_fresh, n_out_fresh;

    // Next state and datapath command.
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_fresh     = r_fresh;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_fresh = r_out_fresh;
        o_cmd.op    = DP_NONE;
        o_cmd.sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_TICK: begin
                            o_cmd.op = DP_TICK;
                        end
                        KIND_CLEAR: begin
                            o_cmd.op = DP_CLEAR;
                        end
                        KIND_SAMPLE: begin
                            if (i_stat.due) begin
                                o_cmd.op = DP_CAPTURE;
                                n_sel    = MS_INTEG;
                                n_state  = S_MSTART;
                            end else begin
                                n_fresh = 1'b0;
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            o_cmd.op = DP_NONE;
                        end
                    endcase
                end
            end
            S_MSTART: begin
                o_cmd.op = DP_MUL_START;
                n_state  = S_MRUN;
            end
            S_MRUN: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = DP_MUL_TAKE;
                    case (r_sel)
                        MS_INTEG: begin
                            n_sel   = MS_PROP;
                            n_state = S_MSTART;
                        end
                        MS_PROP: begin
                            n_sel   = MS_IGAIN;
                            n_state = S_MSTART;
                        end
                        MS_IGAIN: begin
                            n_sel   = MS_DERIV;
                            n_state = S_MSTART;
                        end
                        default: begin
                            n_state = S_DSTART;
                        end
                    endcase
                end
            end
            S_DSTART: begin
                o_cmd.op = DP_DIV_START;
                n_state  = S_DRUN;
            end
            S_DRUN: begin
                if (i_stat.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.op = DP_FINISH;
                n_fresh  = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = DP_EMIT;
                    n_out_valid = 1'b1;
                    n_out_fresh = r_fresh;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= MS_INTEG;
            r_fresh     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_fresh <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            r_out_fresh <= n_out_fresh;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_fresh = r_out_fresh;

endmodule

// ===== design/ptmc_datapath.sv =====
// ----------------------------------------------------------------------------
// ptmc_datapath
// Registers, state and arithmetic of the PID controller: a shared
// shift-add multiplier with saturation, a restoring divider by the
// elapsed ticks, and the final sum and clamp.
// ----------------------------------------------------------------------------
module ptmc_datapath #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int TIMER_WIDTH    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0]        i_measured,
    input  logic signed [DATA_WIDTH-1:0]        i_setpoint,
    input  ptmc_pkg::t_dp_cmd                   i_cmd,
    output ptmc_pkg::t_dp_stat                  o_stat,
    output logic signed [DATA_WIDTH-1:0]        o_drive
);
    import ptmc_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int TW = TIMER_WIDTH;
    localparam int EW = DW + 1;
    localparam int AW = DW + 2;
    localparam int BW = GAIN_W + 1;
    localparam int MW = (AW + BW > 64) ? AW + BW : 64;
    localparam int QW = 63;
    localparam int CW = $clog2(QW + 1);
    localparam logic [DW-1:0] LOWER_RST = DW'(32'h0000_8000);
    localparam logic [DW-1:0] UPPER_RST = DW'(32'h0000_7FFF);

    // Configuration registers.
    logic signed [GAIN_W-1:0]   r_prop_gain, r_integ_gain, r_deriv_gain;
    logic        [PERIOD_W-1:0] r_period;
    logic signed [DW-1:0]       r_lower, r_upper;
    logic        [1:0]          r_mode;

    // Controller state.
    logic        [TW-1:0] r_elapsed;
    logic signed [DW-1:0] r_integral, r_last_meas, r_held, r_meas, r_out_drive;
    logic signed [EW-1:0] r_last_error, r_e, r_dm;
    logic signed [63:0]   r_tp, r_ti, r_dprod;

    // Multiplier and divider.
    logic [MW-1:0] r_mcand, r_acc;
    logic [BW-1:0] r_mplier;
    logic          r_mneg;
    logic [QW-1:0] r_dvd;
    logic [TW:0]   r_rem;
    logic [CW-1:0] r_dcnt;
    logic          r_dneg;

    logic signed [EW-1:0] e_new, dm_new;
    logic signed [AW-1:0] a_op;
    logic signed [BW-1:0] b_op;
    logic        [AW-1:0] a_mag;
    logic        [BW-1:0] b_mag;
    logic        [62:0]   prod_mag;
    logic signed [63:0]   prod, integ_sum, dp_mag, quo, td, sum_all;
    logic signed [DW-1:0] integ_new, drive_new;
    logic                 mode_err, p_on_meas;
    logic        [TW:0]   rem_sh;
    logic                 rem_ge;

    function automatic logic signed [DW-1:0] clamp_lim(
        input logic signed [63:0] v,
        input logic signed [DW-1:0] lo,
        input logic signed [DW-1:0] hi
    );
        logic signed [63:0] t;
        t = v;
        if (t > 64'(hi)) begin
            t = 64'(hi);
        end
        if (t < 64'(lo)) begin
            t = 64'(lo);
        end
        return t[DW-1:0];
    endfunction

    function automatic logic signed [63:0] sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > $signed({1'b0, SAT_MAG})) begin
            s = $signed({1'b0, SAT_MAG});
        end
        if (s < -$signed({1'b0, SAT_MAG})) begin
            s = -$signed({1'b0, SAT_MAG});
        end
        return s[63:0];
    endfunction

    // Error and measurement change of the incoming sample.
    assign e_new     = EW'(i_setpoint) - EW'(i_measured);
    assign dm_new    = EW'(i_measured) - EW'(r_last_meas);
    assign mode_err  = (r_mode == MODE_DERIV_ERR);
    assign p_on_meas = (r_mode == MODE_ALL_MEAS) || (r_mode == MODE_RESERVED);

    // Multiplier operands for each product.
    always_comb begin
        case (i_cmd.sel)
            MS_INTEG: begin
                a_op = AW'(r_e) + AW'(r_last_error);
                b_op = BW'({1'b0, r_elapsed});
            end
            MS_PROP: begin
                a_op = p_on_meas ? -AW'(r_dm) : AW'(r_e);
                b_op = BW'(r_prop_gain);
            end
            MS_IGAIN: begin
                a_op = AW'(r_integral);
                b_op = BW'(r_integ_gain);
            end
            default: begin
                a_op = mode_err ? (AW'(r_e) - AW'(r_last_error)) : AW'(r_dm);
                b_op = BW'(r_deriv_gain);
            end
        endcase
    end

    assign a_mag = a_op[AW-1] ? AW'(-a_op) : AW'(a_op);
    assign b_mag = b_op[BW-1] ? BW'(-b_op) : BW'(b_op);

    // Saturated signed product.
    assign prod_mag = (r_acc > MW'(SAT_MAG)) ? SAT_MAG[62:0] : r_acc[62:0];
    assign prod     = r_mneg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

    // Trapezoidal integral update, halved with floor.
    assign integ_sum = 64'(r_integral) + (prod >>> 1);
    assign integ_new = clamp_lim(integ_sum, r_lower, r_upper);

    // Divider step and signed quotient.
    assign dp_mag = r_dprod[63] ? -r_dprod : r_dprod;
    assign rem_sh = {r_rem[TW-1:0], r_dvd[QW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_elapsed});
    assign quo    = $signed({1'b0, r_dvd});
    assign td     = (r_dneg ^ !mode_err) ? -quo : quo;

    // Final sum, scaling and clamp.
    assign sum_all   = sat_add(sat_add(r_tp, r_ti), td);
    assign drive_new = clamp_lim(sum_all >>> GAIN_FRAC_BITS, r_lower, r_upper);

    // Configuration and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_period     <= PERIOD_W'(1000);
            r_lower      <= LOWER_RST;
            r_upper      <= UPPER_RST;
            r_mode       <= MODE_DERIV_ERR;
            r_elapsed    <= '0;
            r_integral   <= '0;
            r_last_error <= '0;
            r_last_meas  <= '0;
            r_held       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_PERIOD:     r_period     <= i_cfg_data[PERIOD_W-1:0];
                    CFG_LOWER:      r_lower      <= i_cfg_data[DW-1:0];
                    CFG_UPPER:      r_upper      <= i_cfg_data[DW-1:0];
                    CFG_MODE:       r_mode       <= i_cfg_data[1:0];
                    default:        r_mode       <= r_mode;
                endcase
            end
            case (i_cmd.op)
                DP_TICK: begin
                    if (r_elapsed != '1) begin
                        r_elapsed <= r_elapsed + TW'(1);
                    end
                end
                DP_CLEAR: begin
                    r_integral <= '0;
                end
                DP_MUL_TAKE: begin
                    if (i_cmd.sel == MS_INTEG) begin
                        r_integral <= integ_new;
                    end
                end
                DP_FINISH: begin
                    r_held       <= drive_new;
                    r_last_error <= r_e;
                    r_elapsed    <= '0;
                    if (!mode_err) begin
                        r_last_meas <= r_meas;
                    end
                end
                default: begin
                    r_held <= r_held;
                end
            endcase
        end
    end

    // Multiplier and divider control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
            r_dcnt   <= '0;
        end else begin
            if (i_cmd.op == DP_MUL_START) begin
                r_mplier <= b_mag;
            end else if (r_mplier != '0) begin
                r_mplier <= r_mplier >> 1;
            end
            if (i_cmd.op == DP_DIV_START) begin
                r_dcnt <= CW'(QW);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - CW'(1);
            end
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_CAPTURE) begin
            r_e    <= e_new;
            r_dm   <= dm_new;
            r_meas <= i_measured;
        end
        if (i_cmd.op == DP_MUL_START) begin
            r_mcand <= MW'(a_mag);
            r_acc   <= '0;
            r_mneg  <= a_op[AW-1] ^ b_op[BW-1];
        end else if (r_mplier != '0) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= r_mcand << 1;
        end
        if (i_cmd.op == DP_MUL_TAKE) begin
            case (i_cmd.sel)
                MS_PROP:  r_tp    <= prod;
                MS_IGAIN: r_ti    <= prod;
                MS_DERIV: r_dprod <= prod;
                default:  r_tp    <= r_tp;
            endcase
        end
        if (i_cmd.op == DP_DIV_START) begin
            r_dvd  <= dp_mag[QW-1:0];
            r_rem  <= '0;
            r_dneg <= r_dprod[63];
        end else if (r_dcnt != '0) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_elapsed}) : rem_sh;
            r_dvd <= {r_dvd[QW-2:0], rem_ge};
        end
        if (i_cmd.op == DP_EMIT) begin
            r_out_drive <= r_held;
        end
    end

    assign o_stat.due      = (r_elapsed > TW'(r_period));
    assign o_stat.mul_done = (r_mplier == '0);
    assign o_stat.div_done = (r_dcnt == '0);
    assign o_drive         = r_out_drive;

endmodule

// ===== design/pid_three_mode_controller.sv =====
// ----------------------------------------------------------------------------
// pid_three_mode_controller
// PID regulator with a trapezoidal integral and three derivative modes,
// driven by tick, sample and clear requests.
// ----------------------------------------------------------------------------
// A tick or clear request is handled in the idle state without stalling the
// input. A sample that is not yet due goes straight to the output state and
// returns the held drive with fresh low. A due sample runs four products
// through one shared shift-add multiplier, which runs until the significant
// bits of the gain or elapsed operand are used up, and a restoring divide by
// the elapsed ticks, and then forms the result. The
// input is stalled while a sample is in work; a finished result waits in the
// output register while new requests are taken.
module pid_three_mode_controller #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int TIMER_WIDTH    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ptmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_kind,
    input  logic signed [DATA_WIDTH-1:0]    i_measured,
    input  logic signed [DATA_WIDTH-1:0]    i_setpoint,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [DATA_WIDTH-1:0]    o_drive,
    output logic                            o_fresh
);
    import ptmc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    ptmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .o_stall     (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out_fresh (o_fresh),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic and state.
    ptmc_datapath #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .TIMER_WIDTH    (TIMER_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_measured  (i_measured),
        .i_setpoint  (i_setpoint),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_drive     (o_drive)
    );

`include "pid_three_mode_controller_assert.svh"

    // An accepted sample always occupies the sequencer for the next cycle.
    `PTMC_ASSERT_NEXT(a_sample_busy, i_valid && !o_stall && (i_kind == KIND_SAMPLE), o_stall)
    // A new result appears only after a sample has held off the input.
    `PTMC_ASSERT_SAME(a_result_after_sample, $rose(o_valid), $past(o_stall))
    // A tick never produces a result.
    `PTMC_ASSERT_NEXT(a_tick_silent, i_valid && !o_stall && (i_kind == KIND_TICK) && !o_valid,
                      !o_valid)

endmodule
